@@ rtl/gam_pkg.sv @@
// gam_pkg: shared constants, register codes and control types for the gyro-assisted
// arcade mix unit
// no dependencies
package gam_pkg;

	// default fraction bits of the Q format
	localparam int FRAC_BITS_DEF = 14;

	// port widths
	localparam int IN_W       = 16;
	localparam int OUT_W      = 16;
	localparam int SCALE_W    = 12;
	localparam int GAIN_W     = 16;
	localparam int LIMIT_W    = 15;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// correction product is scaled down by this many bits, rounded
	localparam int GAIN_SHIFT = 22;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TURN_RATE_SCALE  = 2'd0,
		REG_CORRECTION_GAIN  = 2'd1,
		REG_CORRECTION_LIMIT = 2'd2
	} gam_reg_t;

	// register reset values
	localparam logic [SCALE_W-1:0] SCALE_RST = 12'd320;
	localparam logic [GAIN_W-1:0]  GAIN_RST  = 16'd524;
	localparam logic [LIMIT_W-1:0] LIMIT_RST = 15'd3277;

	// per-request control that rides along the divider chain
	typedef struct packed {
		logic sign_l;
		logic sign_r;
		logic div_en;
	} gam_ctl_t;

	// magnitude bits that cover both a 16-bit input and one in Q format
	function automatic int frac_max(input int p);
		return (p > 15) ? p : 15;
	endfunction

endpackage

@@ rtl/gam_front.sv @@
// gam_front: clamp, gyro correction and mixing pipeline, five stages
// ends with the dividend, divisor and preloaded quotient for the divider chain
// depends on gam_pkg
module gam_front import gam_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int NW        = frac_max(FRAC_BITS) + FRAC_BITS + 4,
	parameter int DW        = frac_max(FRAC_BITS) + 3,
	parameter int QW        = FRAC_BITS + 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [IN_W-1:0]     throttle,
	input  logic signed [IN_W-1:0]     turn,
	input  logic signed [IN_W-1:0]     angular_rate,
	input  logic [SCALE_W-1:0]         turn_rate_scale,
	input  logic [GAIN_W-1:0]          correction_gain,
	input  logic [LIMIT_W-1:0]         correction_limit,
	output logic                       dn_valid,
	input  logic                       dn_ready,
	output gam_ctl_t                   ctl,
	output logic [NW-1:0]              rem_l,
	output logic [NW-1:0]              rem_r,
	output logic [DW-1:0]              den,
	output logic [QW-1:0]              q_l,
	output logic [QW-1:0]              q_r
);

	localparam int MAXB = frac_max(FRAC_BITS);
	localparam int TW   = MAXB + 2;
	localparam int PW   = TW + SCALE_W + 1;
	localparam int EW   = MAXB + 17;
	localparam int EMW  = EW - 1;
	localparam int GPW  = EMW + GAIN_W;
	localparam int CMW  = GPW + 1 - GAIN_SHIFT;
	localparam int LW   = MAXB + 3;
	localparam int MW   = LW - 1;

	localparam logic signed [TW-1:0] ONE_T     = {{(TW-1){1'b0}}, 1'b1} << FRAC_BITS;
	localparam logic signed [TW-1:0] NEG_ONE_T = -ONE_T;
	localparam logic [MW-1:0]        ONE_M     = {{(MW-1){1'b0}}, 1'b1} << FRAC_BITS;
	localparam logic [QW-1:0]        ONE_Q     = {{(QW-1){1'b0}}, 1'b1} << FRAC_BITS;
	localparam logic [GPW:0]         RND       = {{GPW{1'b0}}, 1'b1} << (GAIN_SHIFT - 1);

	// stage valids and ready chain
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;

	assign rdy5     = !v_s5 || dn_ready;
	assign rdy4     = !v_s4 || rdy5;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;
	assign dn_valid = v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	// stage 1: clamp commands, turn times rate scale
	logic signed [TW-1:0]   thr_x, trn_x, thr_c, trn_c;
	logic signed [TW-1:0]   thr_s1, trn_s1;
	logic signed [IN_W-1:0] rate_s1;
	logic signed [PW-1:0]   prod_s1;

	always_comb begin
		thr_x = $signed({{(TW-IN_W){throttle[IN_W-1]}}, throttle});
		trn_x = $signed({{(TW-IN_W){turn[IN_W-1]}}, turn});
		thr_c = (thr_x > ONE_T) ? ONE_T : ((thr_x < NEG_ONE_T) ? NEG_ONE_T : thr_x);
		trn_c = (trn_x > ONE_T) ? ONE_T : ((trn_x < NEG_ONE_T) ? NEG_ONE_T : trn_x);
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			thr_s1  <= thr_c;
			trn_s1  <= trn_c;
			rate_s1 <= angular_rate;
			prod_s1 <= $signed({{(PW-TW){trn_c[TW-1]}}, trn_c})
				* $signed({{(PW-SCALE_W){1'b0}}, turn_rate_scale});
		end
	end

	// stage 2: rate error, split into sign and magnitude
	logic signed [EW-1:0] err;
	logic [EW-1:0]        err_abs;
	logic [EMW-1:0]       emag_s2;
	logic                 esign_s2;
	logic signed [TW-1:0] thr_s2, trn_s2;

	always_comb begin
		err = $signed({{(EW-PW){prod_s1[PW-1]}}, prod_s1})
			- ($signed({{(EW-IN_W){rate_s1[IN_W-1]}}, rate_s1}) <<< FRAC_BITS);
		err_abs = err[EW-1] ? -err : err;
	end

	always_ff @(posedge clk) begin
		if (rdy2) begin
			emag_s2  <= err_abs[EMW-1:0];
			esign_s2 <= err[EW-1];
			thr_s2   <= thr_s1;
			trn_s2   <= trn_s1;
		end
	end

	// stage 3: error magnitude times gain
	logic [GPW-1:0]       gp_s3;
	logic                 esign_s3;
	logic signed [TW-1:0] thr_s3, trn_s3;

	always_ff @(posedge clk) begin
		if (rdy3) begin
			gp_s3    <= {{GAIN_W{1'b0}}, emag_s2} * {{EMW{1'b0}}, correction_gain};
			esign_s3 <= esign_s2;
			thr_s3   <= thr_s2;
			trn_s3   <= trn_s2;
		end
	end

	// stage 4: round, clamp to limit, mix left and right
	logic [GPW:0]         gsum;
	logic [CMW-1:0]       cm;
	logic [LIMIT_W-1:0]   cmin;
	logic signed [LW-1:0] cx, cv, tx, ux, l_w, r_w;
	logic signed [LW-1:0] l_s4, r_s4;

	always_comb begin
		gsum = {1'b0, gp_s3} + RND;
		cm   = gsum[GPW:GAIN_SHIFT];
		cmin = (cm > {{(CMW-LIMIT_W){1'b0}}, correction_limit})
			? correction_limit : cm[LIMIT_W-1:0];
		cx   = $signed({{(LW-LIMIT_W){1'b0}}, cmin});
		cv   = esign_s3 ? -cx : cx;
		tx   = $signed({{(LW-TW){thr_s3[TW-1]}}, thr_s3});
		ux   = $signed({{(LW-TW){trn_s3[TW-1]}}, trn_s3});
		l_w  = tx - ux - cv;
		r_w  = tx + ux + cv;
	end

	always_ff @(posedge clk) begin
		if (rdy4) begin
			l_s4 <= l_w;
			r_s4 <= r_w;
		end
	end

	// stage 5: peak magnitude, dividend and divisor, or pass-through quotient
	logic [LW-1:0] l_abs, r_abs;
	logic [MW-1:0] lmag, rmag, mpk;
	logic          need_div;
	gam_ctl_t      ctl_s5;
	logic [NW-1:0] rem_l_s5, rem_r_s5;
	logic [DW-1:0] den_s5;
	logic [QW-1:0] q_l_s5, q_r_s5;

	always_comb begin
		l_abs    = l_s4[LW-1] ? -l_s4 : l_s4;
		r_abs    = r_s4[LW-1] ? -r_s4 : r_s4;
		lmag     = l_abs[MW-1:0];
		rmag     = r_abs[MW-1:0];
		mpk      = (lmag > rmag) ? lmag : rmag;
		need_div = mpk > ONE_M;
	end

	always_ff @(posedge clk) begin
		if (rdy5) begin
			ctl_s5.sign_l <= l_s4[LW-1];
			ctl_s5.sign_r <= r_s4[LW-1];
			ctl_s5.div_en <= need_div;
			rem_l_s5 <= ({{(NW-MW){1'b0}}, lmag} << (FRAC_BITS + 1))
				+ {{(NW-MW){1'b0}}, mpk};
			rem_r_s5 <= ({{(NW-MW){1'b0}}, rmag} << (FRAC_BITS + 1))
				+ {{(NW-MW){1'b0}}, mpk};
			den_s5   <= {mpk, 1'b0};
			q_l_s5   <= need_div ? '0 : lmag[QW-1:0];
			q_r_s5   <= need_div ? '0 : rmag[QW-1:0];
		end
	end

	assign ctl   = ctl_s5;
	assign rem_l = rem_l_s5;
	assign rem_r = rem_r_s5;
	assign den   = den_s5;
	assign q_l   = q_l_s5;
	assign q_r   = q_r_s5;

	// a pass-through quotient never exceeds one
	a_bypass_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && !ctl_s5.div_en) |-> (q_l_s5 <= ONE_Q && q_r_s5 <= ONE_Q))
		else $error("pass-through quotient above one");

endmodule

@@ rtl/gam_div_cell.sv @@
// gam_div_cell: one restoring-division cell, decides one quotient bit for both lanes
// and hands the partial remainders to the next cell; depends on gam_pkg
module gam_div_cell import gam_pkg::*; #(
	parameter int NW  = frac_max(FRAC_BITS_DEF) + FRAC_BITS_DEF + 4,
	parameter int DW  = frac_max(FRAC_BITS_DEF) + 3,
	parameter int QW  = FRAC_BITS_DEF + 1,
	parameter int BIT = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          up_valid,
	output logic          up_ready,
	input  gam_ctl_t      ctl_in,
	input  logic [NW-1:0] rem_l_in,
	input  logic [NW-1:0] rem_r_in,
	input  logic [DW-1:0] den_in,
	input  logic [QW-1:0] q_l_in,
	input  logic [QW-1:0] q_r_in,
	output logic          dn_valid,
	input  logic          dn_ready,
	output gam_ctl_t      ctl_out,
	output logic [NW-1:0] rem_l_out,
	output logic [NW-1:0] rem_r_out,
	output logic [DW-1:0] den_out,
	output logic [QW-1:0] q_l_out,
	output logic [QW-1:0] q_r_out
);

	logic          valid_q;
	gam_ctl_t      ctl_q;
	logic [NW-1:0] rem_l_q, rem_r_q;
	logic [DW-1:0] den_q;
	logic [QW-1:0] q_l_q, q_r_q;

	// trial subtract of the shifted divisor
	logic [NW-1:0] dsh, dsh_q;
	logic          fit_l, fit_r;

	always_comb begin
		dsh   = {{(NW-DW){1'b0}}, den_in} << BIT;
		dsh_q = {{(NW-DW){1'b0}}, den_q} << BIT;
		fit_l = ctl_in.div_en && (rem_l_in >= dsh);
		fit_r = ctl_in.div_en && (rem_r_in >= dsh);
	end

	assign up_ready = !valid_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	// quotient bit and remainder update
	always_ff @(posedge clk) begin
		if (up_ready) begin
			ctl_q   <= ctl_in;
			den_q   <= den_in;
			rem_l_q <= fit_l ? (rem_l_in - dsh) : rem_l_in;
			rem_r_q <= fit_r ? (rem_r_in - dsh) : rem_r_in;
			q_l_q   <= q_l_in | ({{(QW-1){1'b0}}, fit_l} << BIT);
			q_r_q   <= q_r_in | ({{(QW-1){1'b0}}, fit_r} << BIT);
		end
	end

	assign dn_valid  = valid_q;
	assign ctl_out   = ctl_q;
	assign rem_l_out = rem_l_q;
	assign rem_r_out = rem_r_q;
	assign den_out   = den_q;
	assign q_l_out   = q_l_q;
	assign q_r_out   = q_r_q;

	// restoring invariant: remainder stays below the divisor at this weight
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && ctl_q.div_en) |-> (rem_l_q < dsh_q && rem_r_q < dsh_q))
		else $error("division remainder out of bound");

	// pass-through requests keep their quotient
	a_bypass_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(up_valid && up_ready && !ctl_in.div_en)
		|=> (q_l_q == $past(q_l_in) && q_r_q == $past(q_r_in)))
		else $error("pass-through quotient changed in divider");

endmodule

@@ rtl/gyro_assisted_arcade_mix_unit.sv @@
// gyro_assisted_arcade_mix_unit: five front stages, one divider cell per quotient bit (FRAC_BITS+1),
// one output register. throughput one request per cycle while out_ready is high; every stage moves
// on its own ready, so bubbles close up.
// reset clears all valid bits and loads the register defaults (320, 524, 3277).
// depends on gam_pkg, gam_front, gam_div_cell
module gyro_assisted_arcade_mix_unit import gam_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [IN_W-1:0]  throttle,
	input  logic signed [IN_W-1:0]  turn,
	input  logic signed [IN_W-1:0]  angular_rate,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [OUT_W-1:0] left_drive,
	output logic signed [OUT_W-1:0] right_drive,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data
);

	localparam int MAXB  = frac_max(FRAC_BITS);
	localparam int LW    = MAXB + 3;
	localparam int NW    = MAXB + FRAC_BITS + 4;
	localparam int DW    = MAXB + 3;
	localparam int QW    = FRAC_BITS + 1;
	localparam int NCELL = FRAC_BITS + 1;
	localparam int ONE_I = 1 << FRAC_BITS;

	// configuration registers
	logic [SCALE_W-1:0] scale_q;
	logic [GAIN_W-1:0]  gain_q;
	logic [LIMIT_W-1:0] limit_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RST;
			gain_q  <= GAIN_RST;
			limit_q <= LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_TURN_RATE_SCALE:  scale_q <= cfg_data[SCALE_W-1:0];
				REG_CORRECTION_GAIN:  gain_q  <= cfg_data[GAIN_W-1:0];
				REG_CORRECTION_LIMIT: limit_q <= cfg_data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// links between front, divider cells and output register
	logic          vld_c [0:NCELL];
	logic          rdy_c [0:NCELL];
	gam_ctl_t      ctl_c [0:NCELL];
	logic [NW-1:0] rem_l_c [0:NCELL];
	logic [NW-1:0] rem_r_c [0:NCELL];
	logic [DW-1:0] den_c [0:NCELL];
	logic [QW-1:0] q_l_c [0:NCELL];
	logic [QW-1:0] q_r_c [0:NCELL];

	gam_front #(
		.FRAC_BITS (FRAC_BITS),
		.NW        (NW),
		.DW        (DW),
		.QW        (QW)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.throttle         (throttle),
		.turn             (turn),
		.angular_rate     (angular_rate),
		.turn_rate_scale  (scale_q),
		.correction_gain  (gain_q),
		.correction_limit (limit_q),
		.dn_valid         (vld_c[0]),
		.dn_ready         (rdy_c[0]),
		.ctl              (ctl_c[0]),
		.rem_l            (rem_l_c[0]),
		.rem_r            (rem_r_c[0]),
		.den              (den_c[0]),
		.q_l              (q_l_c[0]),
		.q_r              (q_r_c[0])
	);

	// divider chain, most significant quotient bit first
	for (genvar k = 0; k < NCELL; k++) begin : g_cell
		gam_div_cell #(
			.NW  (NW),
			.DW  (DW),
			.QW  (QW),
			.BIT (FRAC_BITS - k)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.up_valid  (vld_c[k]),
			.up_ready  (rdy_c[k]),
			.ctl_in    (ctl_c[k]),
			.rem_l_in  (rem_l_c[k]),
			.rem_r_in  (rem_r_c[k]),
			.den_in    (den_c[k]),
			.q_l_in    (q_l_c[k]),
			.q_r_in    (q_r_c[k]),
			.dn_valid  (vld_c[k+1]),
			.dn_ready  (rdy_c[k+1]),
			.ctl_out   (ctl_c[k+1]),
			.rem_l_out (rem_l_c[k+1]),
			.rem_r_out (rem_r_c[k+1]),
			.den_out   (den_c[k+1]),
			.q_l_out   (q_l_c[k+1]),
			.q_r_out   (q_r_c[k+1])
		);
	end

	// output register: apply sign, drives are negated
	logic                 out_valid_q;
	logic [OUT_W-1:0]     left_q, right_q;
	logic signed [LW-1:0] ql_x, qr_x, lo_w, ro_w;

	assign rdy_c[NCELL] = !out_valid_q || out_ready;

	always_comb begin
		ql_x = $signed({{(LW-QW){1'b0}}, q_l_c[NCELL]});
		qr_x = $signed({{(LW-QW){1'b0}}, q_r_c[NCELL]});
		lo_w = ctl_c[NCELL].sign_l ? ql_x : -ql_x;
		ro_w = ctl_c[NCELL].sign_r ? qr_x : -qr_x;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rdy_c[NCELL]) begin
			out_valid_q <= vld_c[NCELL];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_c[NCELL]) begin
			left_q  <= lo_w[OUT_W-1:0];
			right_q <= ro_w[OUT_W-1:0];
		end
	end

	assign out_valid   = out_valid_q;
	assign left_drive  = $signed(left_q);
	assign right_drive = $signed(right_q);

	// drives stay within one when one fits the output format
	a_left_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(FRAC_BITS <= 14 && out_valid)
		|-> ($signed(left_drive) <= ONE_I && $signed(left_drive) >= -ONE_I))
		else $error("left drive beyond full scale");

	a_right_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(FRAC_BITS <= 14 && out_valid)
		|-> ($signed(right_drive) <= ONE_I && $signed(right_drive) >= -ONE_I))
		else $error("right drive beyond full scale");

endmodule

@@ test/tb.sv @@
// tb: self-checking bench for gyro_assisted_arcade_mix_unit; directed and random mix requests
// are checked against a fixed-point predictor of the drive mix, with register writes between phases
// depends on gam_pkg and gyro_assisted_arcade_mix_unit
module tb import gam_pkg::*;;

	localparam int FRAC           = FRAC_BITS_DEF;
	localparam int LATENCY        = FRAC + 7;
	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int PHASES         = 8;
	localparam int PHASE_ITEMS    = 250;
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

	typedef struct packed {
		logic signed [IN_W-1:0] throttle;
		logic signed [IN_W-1:0] turn;
		logic signed [IN_W-1:0] rate;
		int                     gap;
	} mix_cmd_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] left;
		logic signed [OUT_W-1:0] right;
	} drive_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [IN_W-1:0] throttle = '0;
	logic signed [IN_W-1:0] turn = '0;
	logic signed [IN_W-1:0] angular_rate = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [OUT_W-1:0] left_drive;
	logic signed [OUT_W-1:0] right_drive;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// register copies used by the predictor
	logic [SCALE_W-1:0] scale_shadow = SCALE_RST;
	logic [GAIN_W-1:0]  gain_shadow  = GAIN_RST;
	logic [LIMIT_W-1:0] limit_shadow = LIMIT_RST;

	mix_cmd_t cmd_queue[$];
	drive_t   drive_expected[$];
	mix_cmd_t cur_cmd;
	drive_t   want;
	bit       tx_busy = 0;
	bit       tx_steady = 0;
	bit       rx_steady = 0;
	bit       fire;
	int       gap_left = 0;
	int       rx_wait = 0;
	int       long_wait = 0;
	int       hold_requests = 0;
	int       hold_served = 0;
	int       idle_cycles = 0;
	int       errors = 0;

	gyro_assisted_arcade_mix_unit #(.FRAC_BITS(FRAC)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.throttle(throttle),
		.turn(turn),
		.angular_rate(angular_rate),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.left_drive(left_drive),
		.right_drive(right_drive),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	function automatic longint clamp_one(longint v, longint one);
		return (v > one) ? one : ((v < -one) ? -one : v);
	endfunction

	// scale v by one/m, rounded to nearest with ties away from zero
	function automatic longint rescale_q(longint v, longint m, longint one);
		longint mag, q;
		mag = (v < 0) ? -v : v;
		q = (2 * mag * one + m) / (2 * m);
		return (v < 0) ? -q : q;
	endfunction

	// expected drive pair for one mix request under the given registers
	function automatic drive_t mix_drive(mix_cmd_t c, logic [SCALE_W-1:0] scale,
			logic [GAIN_W-1:0] gain, logic [LIMIT_W-1:0] limit);
		longint one, t, u, e, emag, cmag, corr, lim, l, r, lmag, rmag, m, nl, nr;
		drive_t d;
		one = longint'(1) << FRAC;
		t = clamp_one(longint'(c.throttle), one);
		u = clamp_one(longint'(c.turn), one);
		e = u * longint'(scale) - longint'(c.rate) * one;
		emag = (e < 0) ? -e : e;
		cmag = (emag * longint'(gain) + (longint'(1) << (GAIN_SHIFT - 1))) >>> GAIN_SHIFT;
		corr = (e < 0) ? -cmag : cmag;
		lim = longint'(limit);
		corr = (corr > lim) ? lim : ((corr < -lim) ? -lim : corr);
		l = t - u - corr;
		r = t + u + corr;
		lmag = (l < 0) ? -l : l;
		rmag = (r < 0) ? -r : r;
		m = (lmag > rmag) ? lmag : rmag;
		// normalize when either side overshoots full scale
		if (m > one) begin
			l = rescale_q(l, m, one);
			r = rescale_q(r, m, one);
		end
		nl = -l;
		nr = -r;
		d.left = nl[OUT_W-1:0];
		d.right = nr[OUT_W-1:0];
		return d;
	endfunction

	// throttle or turn: mostly in range, with extremes and full-width values
	function automatic logic signed [IN_W-1:0] rand_command();
		case ($urandom_range(0, 11))
			0, 1: return IN_W'($urandom_range(0, 65535));
			2: return 16'sh8000;
			3: return 16'sh7FFF;
			4: return $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
			5: return $urandom_range(0, 1) ? 16'sd16385 : -16'sd16385;
			default: return IN_W'(int'($urandom_range(0, 32768)) - 16384);
		endcase
	endfunction

	// gyro rate: mostly near the setpoint so the correction stays out of its clamp
	function automatic logic signed [IN_W-1:0] rand_rate(logic signed [IN_W-1:0] u_cmd);
		longint u, target;
		if ($urandom_range(0, 3) == 0)
			return IN_W'($urandom_range(0, 65535));
		u = clamp_one(longint'(u_cmd), longint'(1) << FRAC);
		target = ((u * longint'(scale_shadow)) >>> FRAC) + longint'($urandom_range(0, 400)) - 200;
		target = (target > 32767) ? 32767 : ((target < -32768) ? -32768 : target);
		return target[IN_W-1:0];
	endfunction

	task automatic queue_cmd(logic signed [IN_W-1:0] t, logic signed [IN_W-1:0] u,
			logic signed [IN_W-1:0] r);
		mix_cmd_t c;
		c.throttle = t;
		c.turn = u;
		c.rate = r;
		c.gap = tx_steady ? 0 : int'($urandom_range(0, 6));
		cmd_queue.push_back(c);
	endtask

	// wait until every queued request has been accepted and answered
	task automatic drain();
		while (cmd_queue.size() != 0 || tx_busy || drive_expected.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_TURN_RATE_SCALE:  scale_shadow = data[SCALE_W-1:0];
			REG_CORRECTION_GAIN:  gain_shadow = data[GAIN_W-1:0];
			REG_CORRECTION_LIMIT: limit_shadow = data[LIMIT_W-1:0];
			default: ;
		endcase
	endtask

	// request driver: presents queued commands, idling after each as drawn
	always @(posedge clk) begin
		if (arst_n) begin
			fire = in_valid && in_ready;
			if (fire) begin
				drive_expected.push_back(mix_drive(cur_cmd, scale_shadow, gain_shadow,
					limit_shadow));
				gap_left = cur_cmd.gap;
			end
			if (!in_valid || fire) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
					tx_busy = 0;
				end else if (cmd_queue.size() > 0) begin
					cur_cmd = cmd_queue.pop_front();
					throttle <= cur_cmd.throttle;
					turn <= cur_cmd.turn;
					angular_rate <= cur_cmd.rate;
					in_valid <= 1'b1;
					tx_busy = 1;
				end else begin
					in_valid <= 1'b0;
					tx_busy = 0;
				end
			end
		end
	end

	// result monitor: checks drive pairs in order and applies receiver stalls
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (drive_expected.size() == 0) begin
					$display("%0t: unexpected result left=%0d right=%0d", $time,
						left_drive, right_drive);
					errors++;
				end else begin
					want = drive_expected.pop_front();
					if (left_drive !== want.left) begin
						$display("%0t: left_drive expected %0d got %0d", $time,
							want.left, left_drive);
						errors++;
					end
					if (right_drive !== want.right) begin
						$display("%0t: right_drive expected %0d got %0d", $time,
							want.right, right_drive);
						errors++;
					end
				end
				rx_wait = rx_steady ? 0 : int'($urandom_range(0, 6));
			end
			if (hold_served != hold_requests) begin
				long_wait = HOLD_CYCLES;
				hold_served++;
			end
			if (long_wait > 0) begin
				long_wait--;
				out_ready <= 1'b0;
			end else if (rx_wait > 0) begin
				rx_wait--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// watchdog on cycles with no request moving on any channel
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else
			idle_cycles++;
	end

	// stimulus
	initial begin
		logic signed [IN_W-1:0] u;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// reset registers: zeros, clamped commands, overshoot, exact setpoint, full-scale rates
		queue_cmd(16'sd0, 16'sd0, 16'sd0);
		queue_cmd(16'sh7FFF, 16'sh8000, 16'sd0);
		queue_cmd(16'sh8000, 16'sh7FFF, 16'sh7FFF);
		queue_cmd(16'sd16384, 16'sd16384, 16'sd0);
		queue_cmd(-16'sd16384, -16'sd16384, 16'sh8000);
		queue_cmd(16'sd16385, -16'sd16385, 16'sd1);
		queue_cmd(-16'sd16385, 16'sd16385, -16'sd1);
		queue_cmd(16'sd8192, 16'sd4096, 16'sd100);
		queue_cmd(16'sd0, 16'sd16384, 16'sd320);
		queue_cmd(16'sd16384, 16'sd0, 16'sh8000);
		drain();

		// zero limit turns the correction off
		write_reg(REG_CORRECTION_LIMIT, 16'd0);
		queue_cmd(16'sd8000, 16'sd3000, -16'sd5000);
		queue_cmd(16'sd16384, -16'sd16384, 16'sh7FFF);
		drain();

		// limit above one with the largest scale and gain
		write_reg(REG_CORRECTION_LIMIT, 16'hFFFF);
		write_reg(REG_TURN_RATE_SCALE, 16'hFFFF);
		write_reg(REG_CORRECTION_GAIN, 16'hFFFF);
		queue_cmd(16'sd0, 16'sd0, 16'sh7FFF);
		queue_cmd(16'sd16384, 16'sd16384, 16'sh8000);
		queue_cmd(-16'sd16384, 16'sd0, 16'sd12345);
		drain();

		// unmapped index is ignored; zero scale and gain
		write_reg(REG_UNMAPPED, 16'h0000);
		write_reg(REG_TURN_RATE_SCALE, 16'd0);
		write_reg(REG_CORRECTION_GAIN, 16'd0);
		queue_cmd(16'sd5000, 16'sd5000, 16'sh7FFF);
		queue_cmd(16'sh8000, 16'sh8000, 16'sh8000);
		drain();

		// random phases, each under its own register setting
		for (int phase = 0; phase < PHASES; phase++) begin
			drain();
			case (phase)
				0: begin
					write_reg(REG_TURN_RATE_SCALE, CFG_DATA_W'(SCALE_RST));
					write_reg(REG_CORRECTION_GAIN, CFG_DATA_W'(GAIN_RST));
					write_reg(REG_CORRECTION_LIMIT, CFG_DATA_W'(LIMIT_RST));
				end
				1: begin
					write_reg(REG_TURN_RATE_SCALE, 16'd0);
					write_reg(REG_CORRECTION_GAIN, 16'd0);
					write_reg(REG_CORRECTION_LIMIT, 16'd0);
				end
				2: begin
					write_reg(REG_TURN_RATE_SCALE, 16'd4095);
					write_reg(REG_CORRECTION_GAIN, 16'd65535);
					write_reg(REG_CORRECTION_LIMIT, 16'd16384);
				end
				3: begin
					write_reg(REG_TURN_RATE_SCALE, 16'hFFFF);
					write_reg(REG_CORRECTION_GAIN, CFG_DATA_W'($urandom_range(0, 2047)));
					write_reg(REG_CORRECTION_LIMIT, 16'hFFFF);
				end
				default: begin
					write_reg(REG_TURN_RATE_SCALE, CFG_DATA_W'($urandom_range(0, 4095)));
					write_reg(REG_CORRECTION_GAIN, $urandom_range(0, 1) ?
						CFG_DATA_W'($urandom_range(0, 2047)) :
						CFG_DATA_W'($urandom_range(0, 65535)));
					write_reg(REG_CORRECTION_LIMIT, CFG_DATA_W'($urandom_range(0, 16384)));
					if ($urandom_range(0, 1))
						write_reg(REG_UNMAPPED, CFG_DATA_W'($urandom_range(0, 65535)));
				end
			endcase
			tx_steady = (phase % 4 == 1) || (phase % 4 == 3);
			rx_steady = (phase % 4 == 2) || (phase % 4 == 3);
			// long receiver hold while the sender keeps offering back to back
			if (phase == 4) begin
				tx_steady = 1;
				hold_requests++;
			end
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				u = rand_command();
				queue_cmd(rand_command(), u, rand_rate(u));
			end
		end

		drain();
		repeat (3 * LATENCY) @(posedge clk);
		if (errors == 0 && drive_expected.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
